@@ hw/rtl/mm_pkg.sv @@
// Shared widths for the matrix multiply block.
// No dependencies; mm_store, mm_front, mm_back and the top level import it.
`default_nettype none

package mm_pkg;

    localparam int ELEM_W = 16;   // one matrix element, two's complement
    localparam int MUL_W  = 32;   // one element product
    localparam int PROD_W = 33;   // one product matrix element, wraps

endpackage

`default_nettype wire

@@ hw/rtl/mm_fifo.sv @@
// Small synchronous queue with push/full and pop/empty sides.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module mm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [W-1:0]                     din,
    output logic                             full,
    input  logic                             pop,
    output logic [W-1:0]                     dout,
    output logic                             empty,
    output logic [$clog2(DEPTH+1)-1:0]       count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mm_store.sv @@
// Element memories for matrices A and B: one write port, registered reads.
// Depends on mm_pkg for the element width.
`default_nettype none

module mm_store
    import mm_pkg::*;
#(
    parameter int DIM = 3
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [$clog2(DIM*DIM)-1:0]           waddr,
    input  logic signed [ELEM_W-1:0]             wdata_a,
    input  logic signed [ELEM_W-1:0]             wdata_b,
    input  logic [$clog2(DIM*DIM)-1:0]           raddr_a,
    input  logic [$clog2(DIM*DIM)-1:0]           raddr_b,
    output logic signed [ELEM_W-1:0]             rdata_a,
    output logic signed [ELEM_W-1:0]             rdata_b
);

    localparam int NELEM = DIM * DIM;

    logic signed [ELEM_W-1:0] a_mem [NELEM];
    logic signed [ELEM_W-1:0] b_mem [NELEM];
    logic signed [ELEM_W-1:0] rd_a_reg;
    logic signed [ELEM_W-1:0] rd_b_reg;

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            a_mem[waddr] <= wdata_a;
            b_mem[waddr] <= wdata_b;
        end
        rd_a_reg <= a_mem[raddr_a];
        rd_b_reg <= b_mem[raddr_b];
    end

endmodule

`default_nettype wire

@@ hw/rtl/mm_front.sv @@
// Front end: accepts element items, fills the stores, then issues one
// command per product element. Depends on mm_pkg.
`default_nettype none

module mm_front
    import mm_pkg::*;
#(
    parameter int DIM = 3
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         push,
    output logic                                         full,
    input  logic signed [ELEM_W-1:0]                     a_elem,
    input  logic signed [ELEM_W-1:0]                     b_elem,
    output logic                                         st_we,
    output logic [$clog2(DIM*DIM)-1:0]                   st_waddr,
    output logic signed [ELEM_W-1:0]                     st_a,
    output logic signed [ELEM_W-1:0]                     st_b,
    input  logic                                         cmd_full,
    output logic                                         cmd_push,
    output logic [$clog2(DIM*DIM)+$clog2(DIM):0]         cmd_data,
    input  logic                                         mat_done
);

    localparam int NELEM = DIM * DIM;
    localparam int IDX_W = $clog2(NELEM);
    localparam int COL_W = $clog2(DIM);
    localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(NELEM - 1);
    localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'((DIM - 1) * DIM);
    localparam logic [IDX_W-1:0] ROW_STEP = IDX_W'(DIM);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(DIM - 1);

    typedef struct packed {
        logic [IDX_W-1:0] row_base;
        logic [COL_W-1:0] col;
        logic             last;
    } cmd_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_ISSUE,
        S_WAIT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             accept;
    logic             cmd_last;
    cmd_t             cmd;

    assign full     = (state_reg != S_LOAD);
    assign accept   = push && !full;
    assign st_we    = accept;
    assign st_waddr = cnt_reg;
    assign st_a     = a_elem;
    assign st_b     = b_elem;

    assign cmd_last     = (row_reg == ROW_LAST) && (col_reg == COL_LAST);
    assign cmd_push     = (state_reg == S_ISSUE) && !cmd_full;
    assign cmd.row_base = row_reg;
    assign cmd.col      = col_reg;
    assign cmd.last     = cmd_last;
    assign cmd_data     = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (cnt_reg == CNT_LAST)
                        begin
                            cnt_reg   <= '0;
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= S_ISSUE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_ISSUE:
                begin
                    if (cmd_push)
                    begin
                        if (cmd_last)
                        begin
                            state_reg <= S_WAIT;
                        end
                        else if (col_reg == COL_LAST)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + ROW_STEP;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                end
                S_WAIT:
                begin
                    // hold the stores until the last element read is issued
                    if (mat_done)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mm_back.sv @@
// Back end: one multiply-accumulate pipeline that turns element commands
// into product elements. Depends on mm_pkg.
`default_nettype none

module mm_back
    import mm_pkg::*;
#(
    parameter int DIM       = 3,
    parameter int OUT_DEPTH = 4
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cmd_empty,
    output logic                                         cmd_pop,
    input  logic [$clog2(DIM*DIM)+$clog2(DIM):0]         cmd_data,
    output logic [$clog2(DIM*DIM)-1:0]                   a_raddr,
    output logic [$clog2(DIM*DIM)-1:0]                   b_raddr,
    input  logic signed [ELEM_W-1:0]                     a_rdata,
    input  logic signed [ELEM_W-1:0]                     b_rdata,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]               out_count,
    output logic                                         res_push,
    output logic [PROD_W-1:0]                            res_data,
    output logic                                         res_last,
    output logic                                         mat_done
);

    localparam int NELEM = DIM * DIM;
    localparam int IDX_W = $clog2(NELEM);
    localparam int COL_W = $clog2(DIM);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int CR_W  = CNT_W + 2;
    localparam logic [COL_W-1:0] K_LAST = COL_W'(DIM - 1);
    localparam logic [IDX_W-1:0] B_STEP = IDX_W'(DIM);

    typedef struct packed {
        logic [IDX_W-1:0] row_base;
        logic [COL_W-1:0] col;
        logic             last;
    } cmd_t;

    cmd_t                     cmd;
    logic                     issue_reg;
    logic [COL_W-1:0]         k_reg;
    logic [IDX_W-1:0]         a_addr_reg;
    logic [IDX_W-1:0]         b_addr_reg;
    logic                     mlast_reg;
    logic                     rd_valid_reg;
    logic                     rd_first_reg;
    logic                     rd_lastk_reg;
    logic                     rd_mlast_reg;
    logic                     prod_valid_reg;
    logic                     prod_first_reg;
    logic                     prod_lastk_reg;
    logic                     prod_mlast_reg;
    logic signed [MUL_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;
    logic [1:0]               inflight_reg;
    logic [1:0]               inflight_next;
    logic                     issue_free;
    logic                     credit_ok;
    logic                     start;

    assign cmd = cmd_data;

    // a new element may enter on the last term of the previous one
    assign issue_free = !issue_reg || (k_reg == K_LAST);
    assign credit_ok  = (CR_W'(out_count) + CR_W'(inflight_reg)) < CR_W'(OUT_DEPTH);
    assign start      = issue_free && !cmd_empty && credit_ok;
    assign cmd_pop    = start;
    assign mat_done   = issue_reg && (k_reg == K_LAST) && mlast_reg;

    assign a_raddr = a_addr_reg;
    assign b_raddr = b_addr_reg;

    assign acc_next = (prod_first_reg ? '0 : acc_reg)
                    + {{(PROD_W - MUL_W){prod_reg[MUL_W-1]}}, prod_reg};

    assign res_push = prod_valid_reg && prod_lastk_reg;
    assign res_data = acc_next;
    assign res_last = prod_mlast_reg;

    assign inflight_next = inflight_reg + 2'(start) - 2'(res_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg      <= 1'b0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            inflight_reg   <= '0;
        end
        else
        begin
            if (start)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && (k_reg == K_LAST))
            begin
                issue_reg <= 1'b0;
            end
            rd_valid_reg   <= issue_reg;
            prod_valid_reg <= rd_valid_reg;
            inflight_reg   <= inflight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // walk A along a row and B down a column
        if (start)
        begin
            k_reg      <= '0;
            a_addr_reg <= cmd.row_base;
            b_addr_reg <= IDX_W'(cmd.col);
            mlast_reg  <= cmd.last;
        end
        else if (issue_reg)
        begin
            k_reg      <= k_reg + 1'b1;
            a_addr_reg <= a_addr_reg + 1'b1;
            b_addr_reg <= b_addr_reg + B_STEP;
        end

        rd_first_reg <= (k_reg == '0);
        rd_lastk_reg <= (k_reg == K_LAST);
        rd_mlast_reg <= mlast_reg;

        prod_reg       <= a_rdata * b_rdata;
        prod_first_reg <= rd_first_reg;
        prod_lastk_reg <= rd_lastk_reg;
        prod_mlast_reg <= rd_mlast_reg;

        if (prod_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/matrix_multiply_3x3.sv @@
// Top level of the DIM x DIM matrix multiplier.
// Depends on mm_pkg, mm_fifo, mm_store, mm_front and mm_back.
//
// Usage:
//   Input side is a queue: drive a_elem/b_elem with push high; an item is
//   taken at a clock edge where push is high and full is low. Items carry
//   A[i][j] and B[i][j] together, row-major, DIM*DIM items per matrix pair.
//   Result side is a queue too: while empty is low, product/last_out show the
//   oldest product element; pop high at a clock edge takes it. Elements come
//   out row-major, and last_out marks the final one of each product matrix.
//   Loading accepts one item per cycle. After the last item of a pair, full
//   stays high until the last store read of that pair is issued; all reads
//   come from the single multiply-accumulate unit through its one read port
//   per store. The unit starts each new product element on the last term of
//   the previous one when a command is waiting and the result queue has room.
//   A stalled receiver fills the result queue; the multiply unit then
//   holds before starting another element and nothing is lost.
//   Reset empties both queues and restarts loading at element zero; the
//   element stores are not cleared and are always rewritten before use.
//   Products are 33 bits and wrap for DIM above 3.
`default_nettype none

module matrix_multiply_3x3
    import mm_pkg::*;
#(
    parameter int DIM = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic signed [ELEM_W-1:0]  a_elem,
    input  logic signed [ELEM_W-1:0]  b_elem,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [PROD_W-1:0]  product,
    output logic                      last_out
);

    localparam int NELEM     = DIM * DIM;
    localparam int IDX_W     = $clog2(NELEM);
    localparam int COL_W     = $clog2(DIM);
    localparam int CMD_W     = IDX_W + COL_W + 1;
    localparam int CMD_DEPTH = 2;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // store write and read ports
    logic                     st_we;
    logic [IDX_W-1:0]         st_waddr;
    logic signed [ELEM_W-1:0] st_a;
    logic signed [ELEM_W-1:0] st_b;
    logic [IDX_W-1:0]         a_raddr;
    logic [IDX_W-1:0]         b_raddr;
    logic signed [ELEM_W-1:0] a_rdata;
    logic signed [ELEM_W-1:0] b_rdata;

    // command queue between front and back
    logic                     cmd_push;
    logic                     cmd_full;
    logic [CMD_W-1:0]         cmd_wdata;
    logic                     cmd_pop;
    logic                     cmd_empty;
    logic [CMD_W-1:0]         cmd_rdata;
    logic [CMD_CNT_W-1:0]     cmd_count;
    logic                     mat_done;

    // result queue
    logic                     res_push;
    logic                     res_full;
    logic [PROD_W-1:0]        res_data;
    logic                     res_last;
    logic [PROD_W:0]          res_dout;
    logic [OUT_CNT_W-1:0]     res_count;

    mm_front #(
        .DIM (DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .a_elem   (a_elem),
        .b_elem   (b_elem),
        .st_we    (st_we),
        .st_waddr (st_waddr),
        .st_a     (st_a),
        .st_b     (st_b),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_data (cmd_wdata),
        .mat_done (mat_done)
    );

    mm_store #(
        .DIM (DIM)
    ) u_store (
        .clk     (clk),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata_a (st_a),
        .wdata_b (st_b),
        .raddr_a (a_raddr),
        .raddr_b (b_raddr),
        .rdata_a (a_rdata),
        .rdata_b (b_rdata)
    );

    mm_fifo #(
        .W     (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_rdata),
        .empty (cmd_empty),
        .count (cmd_count)
    );

    mm_back #(
        .DIM       (DIM),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_rdata),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .out_count (res_count),
        .res_push  (res_push),
        .res_data  (res_data),
        .res_last  (res_last),
        .mat_done  (mat_done)
    );

    mm_fifo #(
        .W     (PROD_W + 1),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   ({res_data, res_last}),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty),
        .count (res_count)
    );

    assign product  = res_dout[PROD_W:1];
    assign last_out = res_dout[0];

    // credit check in the back end must keep the result queue from overflowing
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // the stores may only be released while the front end holds off new items
    a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
        mat_done |-> full)
        else $error("matrix done seen while front end is loading");

    // the final element of a matrix leaves no command of the same pair behind
    a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_last) |-> (cmd_count == '0))
        else $error("commands still queued at last product element");

endmodule

`default_nettype wire
